// File: rtl/core/pif_pkg.sv
// shared widths, character codes and helpers for the integer formatter
package pif_pkg;

  localparam int LONG_BITS  = 64;
  localparam int COUNT_BITS = 16;

  localparam int CHAR_W   = 8;
  localparam int ARG_W    = 64;
  localparam int CHARS_W  = 16;
  localparam int S_DATA_W = CHAR_W + ARG_W;
  localparam int M_DATA_W = CHAR_W + CHARS_W;

  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = ARG_W / 4;
  localparam int DIG_W      = DEC_DIGITS * 4;
  localparam int REM_W      = $clog2(DEC_DIGITS + 1);
  localparam int PRE_CHARS  = 6;
  localparam int PRE_W      = PRE_CHARS * CHAR_W;
  localparam int PLEN_W     = $clog2(PRE_CHARS + 1);

  localparam logic [ARG_W-1:0]      LONG_MASK = {ARG_W{1'b1}} >> (ARG_W - LONG_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_CAP = {COUNT_BITS{1'b1}};

  localparam logic [1:0] SIZE_INT  = 2'd0;
  localparam logic [1:0] SIZE_LONG = 2'd1;
  localparam logic [1:0] SIZE_LL   = 2'd2;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_C     = 8'h63;
  localparam logic [7:0] CHR_D     = 8'h64;
  localparam logic [7:0] CHR_I     = 8'h69;
  localparam logic [7:0] CHR_L     = 8'h6C;
  localparam logic [7:0] CHR_P     = 8'h70;
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CHR_X     = 8'h78;

  // first character in the low byte
  localparam logic [PRE_W-1:0] NULL_STR =
    {8'h29, 8'h6C, 8'h6C, 8'h75, 8'h6E, 8'h28};
  localparam logic [PRE_W-1:0] PTR_PREFIX = PRE_W'({CHR_X, CHR_ZERO});

  function automatic logic [ARG_W-1:0] mask_arg(input logic [ARG_W-1:0] v,
                                                input logic [1:0] lvl);
    logic [ARG_W-1:0] r;
    case (lvl)
      SIZE_INT:  r = {{(ARG_W-32){1'b0}}, v[31:0]};
      SIZE_LONG: r = v & LONG_MASK;
      default:   r = v;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) r = CHR_ZERO + 8'(d);
    else if (upper) r = CHR_UA + 8'(d) - 8'd10;
    else r = CHR_LA + 8'(d) - 8'd10;
    return r;
  endfunction

endpackage

// File: rtl/core/printf_integer_formatter.sv
// printf-style integer formatter with bit-serial binary to decimal conversion
//
// input stream: one transaction per format character; tdata carries the
// character and the 64-bit argument a conversion would consume, tuser marks
// the first character of a new format string (clears count and escape).
// output stream: one transaction per emitted character with the running
// character count; tlast marks the final character caused by one input.
// s_axis_tready is high only while the sequencer is idle, one item at a time;
// the sequencer is idle again the cycle after it loads its last character into the output register.
// per item: plain characters, %c and %% pass through the prefix state to the
// output register; %x emits its hex digits, skipping leading zeros outside
// the precision (never the last digit); %p emits the null text, else the 0x
// prefix and 16 upper-case hex digits; %d, %i and %u first shift all 64
// argument bits through shift-and-add-3 on a 20-digit bcd shift register,
// then emit an optional sign and the 20 digits, leading zeros skipped alike.
// characters go out at one per cycle while the output register is free.
// a stalled receiver holds the output register and freezes emission; the
// next input item can still be taken while the last character waits.
// reset (rst, synchronous) empties the output register, clears any escape
// and clears the count.
module printf_integer_formatter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pif_pkg::S_DATA_W-1:0]  s_axis_tdata,   // fmt_char, arg_value
  input  logic [0:0]                    s_axis_tuser,   // first
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pif_pkg::M_DATA_W-1:0]  m_axis_tdata,   // out_char, chars_emitted
  output logic                          m_axis_tlast    // last
);
  import pif_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_PRE, S_DIG} state_t;

  state_t                  state;
  logic                    in_escape;
  logic [1:0]              size_level;
  logic                    dot_seen;
  logic [3:0]              prec;
  logic [COUNT_BITS-1:0]   char_count;

  // emission job
  logic [PRE_W-1:0]        pre_chars;
  logic [PLEN_W-1:0]       pre_len;
  logic                    has_dig;
  logic [DIG_W-1:0]        dig;
  logic [ARG_W-1:0]        bin;
  logic [5:0]              cyc;
  logic [REM_W-1:0]        rem;
  logic                    started;
  logic                    upper;

  // output register
  logic [CHAR_W-1:0]       m_char;
  logic [CHARS_W-1:0]      m_count;

  // decoded input
  logic                    acc;
  logic                    first;
  logic [CHAR_W-1:0]       c;
  logic [ARG_W-1:0]        arg;
  logic                    eff_esc;
  logic [1:0]              eff_size;
  logic                    eff_dot;
  logic [3:0]              eff_prec;
  logic [ARG_W-1:0]        masked;
  logic [ARG_W-1:0]        neg_mag;
  logic                    neg;

  logic [DIG_W-1:0]        dig_adj;
  logic                    slot_free;
  logic [3:0]              top;
  logic                    skip;
  logic                    emit;
  logic [CHAR_W-1:0]       emit_char;
  logic                    emit_last;
  logic [COUNT_BITS-1:0]   cnt_inc;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {m_count, m_char};

  always_comb begin
    acc      = s_axis_tvalid && s_axis_tready;
    first    = s_axis_tuser[0];
    c        = s_axis_tdata[CHAR_W-1:0];
    arg      = s_axis_tdata[S_DATA_W-1:CHAR_W];
    // a first character drops any escape in progress
    eff_esc  = in_escape && !first;
    eff_size = first ? SIZE_INT : size_level;
    eff_dot  = dot_seen && !first;
    eff_prec = first ? 4'd0 : prec;
    masked   = mask_arg(arg, eff_size);
    neg_mag  = mask_arg(~masked + 64'd1, eff_size);
    case (eff_size)
      SIZE_INT:  neg = masked[31];
      SIZE_LONG: neg = masked[LONG_BITS-1];
      default:   neg = masked[ARG_W-1];
    endcase

    // double dabble: add 3 to every bcd digit of 5 or more before the shift
    for (int i = 0; i < DEC_DIGITS; i++) begin
      dig_adj[i*4 +: 4] = (dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3 : dig[i*4 +: 4];
    end

    slot_free = !m_axis_tvalid || m_axis_tready;
    top       = dig[DIG_W-1 -: 4];
    // leading zero outside the precision and not the final digit
    skip      = !started && (rem > REM_W'(1)) && (rem > REM_W'(prec)) && (top == 4'd0);

    emit      = 1'b0;
    emit_char = pre_chars[CHAR_W-1:0];
    emit_last = 1'b0;
    if (state == S_PRE) begin
      emit      = slot_free;
      emit_last = (pre_len == PLEN_W'(1)) && !has_dig;
    end else if (state == S_DIG && !skip) begin
      emit      = slot_free;
      emit_char = hex_char(top, upper);
      emit_last = (rem == REM_W'(1));
    end
    cnt_inc = (char_count == COUNT_CAP) ? char_count : char_count + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_escape     <= 1'b0;
      size_level    <= SIZE_INT;
      dot_seen      <= 1'b0;
      prec          <= 4'd0;
      char_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // output register
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_char        <= emit_char;
        m_axis_tlast  <= emit_last;
        m_count       <= CHARS_W'(cnt_inc);
        char_count    <= cnt_inc;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (first) char_count <= '0;
            in_escape  <= eff_esc;
            size_level <= eff_size;
            dot_seen   <= eff_dot;
            prec       <= eff_prec;
            started    <= 1'b0;
            upper      <= 1'b0;
            has_dig    <= 1'b0;
            pre_len    <= '0;
            if (c == CHR_NUL) begin
              in_escape <= 1'b0;
            end else if (eff_esc) begin
              in_escape <= 1'b0;
              unique case (c) inside
                CHR_L: begin
                  in_escape <= 1'b1;
                  if (eff_size != SIZE_LL) size_level <= eff_size + 2'd1;
                end
                CHR_DOT: begin
                  in_escape <= 1'b1;
                  dot_seen  <= 1'b1;
                end
                CHR_ZERO: in_escape <= 1'b1;
                [CHR_ONE:CHR_NINE]: begin
                  in_escape <= 1'b1;
                  if (eff_dot) prec <= 4'(c - CHR_ZERO);
                end
                CHR_PCT: begin
                  pre_chars <= PRE_W'(CHR_PCT);
                  pre_len   <= PLEN_W'(1);
                  state     <= S_PRE;
                end
                CHR_C: begin
                  pre_chars <= PRE_W'(arg[CHAR_W-1:0]);
                  pre_len   <= PLEN_W'(1);
                  state     <= S_PRE;
                end
                CHR_D, CHR_I: begin
                  pre_chars <= PRE_W'(CHR_MINUS);
                  pre_len   <= neg ? PLEN_W'(1) : PLEN_W'(0);
                  bin       <= neg ? neg_mag : masked;
                  dig       <= '0;
                  cyc       <= '0;
                  rem       <= REM_W'(DEC_DIGITS);
                  has_dig   <= 1'b1;
                  state     <= S_CONV;
                end
                CHR_U: begin
                  bin     <= masked;
                  dig     <= '0;
                  cyc     <= '0;
                  rem     <= REM_W'(DEC_DIGITS);
                  has_dig <= 1'b1;
                  state   <= S_CONV;
                end
                CHR_X: begin
                  dig     <= {masked, {(DIG_W-ARG_W){1'b0}}};
                  rem     <= REM_W'(HEX_DIGITS);
                  has_dig <= 1'b1;
                  state   <= S_DIG;
                end
                CHR_P: begin
                  if (arg == '0) begin
                    pre_chars <= NULL_STR;
                    pre_len   <= PLEN_W'(PRE_CHARS);
                  end else begin
                    pre_chars <= PTR_PREFIX;
                    pre_len   <= PLEN_W'(2);
                    dig       <= {arg, {(DIG_W-ARG_W){1'b0}}};
                    rem       <= REM_W'(HEX_DIGITS);
                    has_dig   <= 1'b1;
                    started   <= 1'b1;
                    upper     <= 1'b1;
                  end
                  state <= S_PRE;
                end
                default: ;
              endcase
            end else if (c == CHR_PCT) begin
              in_escape  <= 1'b1;
              size_level <= SIZE_INT;
              dot_seen   <= 1'b0;
              prec       <= 4'd0;
            end else begin
              pre_chars <= PRE_W'(c);
              pre_len   <= PLEN_W'(1);
              state     <= S_PRE;
            end
          end
        end
        S_CONV: begin
          // shift one binary bit into the bcd register per cycle
          dig <= {dig_adj[DIG_W-2:0], bin[ARG_W-1]};
          bin <= {bin[ARG_W-2:0], 1'b0};
          cyc <= cyc + 6'd1;
          if (cyc == 6'd63) state <= (pre_len != '0) ? S_PRE : S_DIG;
        end
        S_PRE: begin
          if (emit) begin
            pre_chars <= pre_chars >> CHAR_W;
            pre_len   <= pre_len - PLEN_W'(1);
            if (pre_len == PLEN_W'(1)) state <= has_dig ? S_DIG : S_IDLE;
          end
        end
        S_DIG: begin
          if (skip || emit) begin
            dig <= dig << 4;
            rem <= rem - REM_W'(1);
            if (emit) started <= 1'b1;
            if (emit && rem == REM_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // digit phase always has a digit left to emit
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    state == S_DIG |-> rem != '0)
    else $error("digit phase with no digits left");

  // prefix phase always has a character left to emit
  a_pre_live: assert property (@(posedge clk) disable iff (rst)
    state == S_PRE |-> pre_len != '0)
    else $error("prefix phase with no characters left");

  // within one input item the count steps by one per character
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid
       || m_axis_tdata[CHAR_W +: CHARS_W] == $past(m_axis_tdata[CHAR_W +: CHARS_W]) + 16'd1
       || $past(m_axis_tdata[CHAR_W +: CHARS_W]) == CHARS_W'(COUNT_CAP)))
    else $error("character count did not advance within an item");

  // no new transaction is taken while a job is in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV || state == S_DIG) |-> !s_axis_tready)
    else $error("input accepted while busy");

endmodule

// File: verif/pif_format_checker.sv
`timescale 1ns / 100ps
// transaction checker for the integer formatter: predicts emitted characters and compares them
module pif_format_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_valid,
  input  logic                         s_ready,
  input  logic [pif_pkg::S_DATA_W-1:0] s_data,
  input  logic                         s_first,
  input  logic                         m_valid,
  input  logic                         m_ready,
  input  logic [pif_pkg::M_DATA_W-1:0] m_data,
  input  logic                         m_last,
  output int                           errors,
  output int                           outstanding
);
  import pif_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [CHARS_W-1:0] count;
  } emitted_t;

  emitted_t expected_chars[$];
  logic [7:0] line_buf[$];

  // formatter state as the software sees it
  logic                  in_esc;
  logic [1:0]            size_lvl;
  logic                  dot_seen;
  logic [3:0]            precision;
  logic [COUNT_BITS-1:0] char_count;

  string lower_hex = "0123456789abcdef";
  string upper_hex = "0123456789ABCDEF";
  string null_text = "(null)";

  function automatic int size_width(input logic [1:0] lvl);
    if (lvl == SIZE_INT) return 32;
    if (lvl == SIZE_LONG) return LONG_BITS;
    return 64;
  endfunction

  function automatic logic [63:0] clip(input logic [63:0] v, input logic [1:0] lvl);
    int bits;
    bits = size_width(lvl);
    if (bits >= 64) return v;
    return v & ((64'd1 << bits) - 64'd1);
  endfunction

  // digits come out least significant first, then get padded to the precision
  task automatic put_number(input logic [63:0] mag, input bit as_hex, input bit neg);
    logic [7:0]  rev[20];
    logic [63:0] m;
    int          n;
    int          i;
    int          d;
    if (neg) line_buf.push_back(CHR_MINUS);
    m = mag;
    n = 0;
    do begin
      if (as_hex) begin
        d = int'(m[3:0]);
        m = m >> 4;
      end else begin
        d = int'(m % 64'd10);
        m = m / 64'd10;
      end
      rev[n] = lower_hex[d];
      n++;
    end while (m != 64'd0);
    for (i = n; i < int'(precision); i++) line_buf.push_back(CHR_ZERO);
    for (i = n - 1; i >= 0; i--) line_buf.push_back(rev[i]);
  endtask

  task automatic put_signed(input logic [63:0] arg);
    logic [63:0] v;
    logic [63:0] sign;
    logic [63:0] mag;
    v    = clip(arg, size_lvl);
    sign = 64'd1 << (size_width(size_lvl) - 1);
    if ((v & sign) != 64'd0) begin
      mag = clip(~v + 64'd1, size_lvl);
      if (mag == 64'd0) mag = sign;
      put_number(mag, 1'b0, 1'b1);
    end else begin
      put_number(v, 1'b0, 1'b0);
    end
  endtask

  task automatic put_pointer(input logic [63:0] arg);
    int i;
    if (arg == 64'd0) begin
      for (i = 0; i < null_text.len(); i++) line_buf.push_back(null_text[i]);
    end else begin
      line_buf.push_back(CHR_ZERO);
      line_buf.push_back(CHR_X);
      for (i = 15; i >= 0; i--) line_buf.push_back(upper_hex[int'(arg[4*i +: 4])]);
    end
  endtask

  task automatic format_step(input logic first_char, input logic [7:0] c,
                             input logic [63:0] arg);
    int k;
    line_buf.delete();
    if (first_char) begin
      char_count = '0;
      in_esc     = 1'b0;
      size_lvl   = SIZE_INT;
      dot_seen   = 1'b0;
      precision  = 4'd0;
    end
    if (c == CHR_NUL) begin
      in_esc = 1'b0;
    end else if (in_esc) begin
      if (c == CHR_L) begin
        if (size_lvl != SIZE_LL) size_lvl = size_lvl + 2'd1;
      end else if (c == CHR_DOT) begin
        dot_seen = 1'b1;
      end else if (c == CHR_ZERO) begin
        // flag character, parsed and ignored
      end else if (c >= CHR_ONE && c <= CHR_NINE) begin
        if (dot_seen) precision = 4'(c - CHR_ZERO);
      end else begin
        case (c)
          CHR_PCT:      line_buf.push_back(CHR_PCT);
          CHR_C:        line_buf.push_back(arg[7:0]);
          CHR_D, CHR_I: put_signed(arg);
          CHR_U:        put_number(clip(arg, size_lvl), 1'b0, 1'b0);
          CHR_X:        put_number(clip(arg, size_lvl), 1'b1, 1'b0);
          CHR_P:        put_pointer(arg);
          default:      ;
        endcase
        in_esc = 1'b0;
      end
    end else if (c == CHR_PCT) begin
      in_esc    = 1'b1;
      size_lvl  = SIZE_INT;
      dot_seen  = 1'b0;
      precision = 4'd0;
    end else begin
      line_buf.push_back(c);
    end
    for (k = 0; k < line_buf.size(); k++) begin
      if (char_count != COUNT_CAP) char_count = char_count + 1'b1;
      expected_chars.push_back('{ch: line_buf[k], last: (k == line_buf.size() - 1),
                                 count: CHARS_W'(char_count)});
    end
  endtask

  task automatic check_char();
    emitted_t want;
    if (expected_chars.size() == 0) begin
      $error("out_char: expected none, actual %h", m_data[CHAR_W-1:0]);
      errors++;
    end else begin
      want = expected_chars.pop_front();
      if (m_data[CHAR_W-1:0] !== want.ch) begin
        $error("out_char: expected %h, actual %h", want.ch, m_data[CHAR_W-1:0]);
        errors++;
      end
      if (m_last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, m_last);
        errors++;
      end
      if (m_data[CHAR_W +: CHARS_W] !== want.count) begin
        $error("chars_emitted: expected %0d, actual %0d", want.count,
               m_data[CHAR_W +: CHARS_W]);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_esc     = 1'b0;
      size_lvl   = SIZE_INT;
      dot_seen   = 1'b0;
      precision  = 4'd0;
      char_count = '0;
      expected_chars.delete();
    end else begin
      if (s_valid && s_ready)
        format_step(s_first, s_data[CHAR_W-1:0], s_data[S_DATA_W-1:CHAR_W]);
      if (m_valid && m_ready) check_char();
    end
    outstanding = expected_chars.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// testbench top for the integer formatter: stimulus, flow control and verdict
module tb;
  import pif_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;  // watchdog, several times the slowest clean run
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_AT      = 150;        // random item count that triggers the long stall
  localparam int DRAIN_AT     = 300;        // random item count where the sender waits for drain
  localparam int CALM_FROM    = 400;        // no idling on either side from here on
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 120;        // longer than the worst decimal conversion

  // characters the package does not name
  localparam logic [7:0] CHR_S = 8'h73;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // fmt_char, arg_value
  logic [0:0]          s_axis_tuser;   // first
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;   // out_char, chars_emitted
  logic                m_axis_tlast;   // last

  int errors;
  int outstanding;
  int sent_count;
  bit quiet;      // suppresses idling on both sides
  bit hold_off;   // asks the receiver for one long stall

  printf_integer_formatter uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  pif_format_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_data      (s_axis_tdata),
    .s_first     (s_axis_tuser[0]),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_data      (m_axis_tdata),
    .m_last      (m_axis_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("printf_integer_formatter: mismatch");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        // the block fills up and must stall its input while the sender keeps offering
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one input transaction, optionally preceded by an idle burst
  task automatic send_fmt(input logic first_char, input logic [7:0] c, input logic [63:0] arg);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {arg, c};
    s_axis_tuser  <= first_char;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_count++;
  endtask

  // sender goes idle until every predicted character has come out
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // argument shapes that hit sign bits, zero, all ones and size boundaries
  function automatic logic [63:0] random_arg();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0:       v = 64'd0;
      1:       v = '1;
      2:       v = 64'($urandom_range(0, 20));
      3:       v = {32'($urandom), 32'h8000_0000};
      4:       v = 64'h8000_0000_0000_0000;
      5:       v = {32'd0, 32'($urandom)};
      6:       v = 64'd1 << $urandom_range(0, 63);
      default: v = {32'($urandom), 32'($urandom)};
    endcase
    return v;
  endfunction

  // a new string starts now and then, sometimes right inside an escape
  function automatic logic fresh();
    return $urandom_range(0, 24) == 0;
  endfunction

  task automatic send_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CHR_PCT);
    send_fmt(fresh(), c, random_arg());
  endtask

  // mostly well-formed conversion specs with random flags, sizes and precision
  task automatic send_random_spec();
    int         pick;
    int         n_l;
    logic [7:0] conv;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_plain();
    end else if (pick < 32) begin
      // noise: any byte, NUL and percent included
      send_fmt(fresh(), 8'($urandom_range(0, 255)), random_arg());
    end else begin
      send_fmt(fresh(), CHR_PCT, random_arg());
      if ($urandom_range(0, 4) == 0) send_fmt(fresh(), CHR_ZERO, random_arg());
      if ($urandom_range(0, 4) == 0)
        send_fmt(fresh(), CHR_ONE + 8'($urandom_range(0, 8)), random_arg());
      pick = $urandom_range(0, 9);
      n_l  = (pick < 5) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
      repeat (n_l) send_fmt(fresh(), CHR_L, random_arg());
      if ($urandom_range(0, 2) == 0) begin
        send_fmt(fresh(), CHR_DOT, random_arg());
        send_fmt(fresh(), CHR_ZERO + 8'($urandom_range(0, 9)), random_arg());
        if ($urandom_range(0, 4) == 0)
          send_fmt(fresh(), CHR_ZERO + 8'($urandom_range(0, 9)), random_arg());
      end
      case ($urandom_range(0, 19))
        0:       conv = CHR_PCT;
        1:       conv = CHR_C;
        2, 3, 4: conv = CHR_D;
        5:       conv = CHR_I;
        6, 7, 8: conv = CHR_U;
        9, 10:   conv = CHR_X;
        11, 12:  conv = CHR_P;
        13:      conv = CHR_S;
        14:      conv = CHR_NUL;
        15:      conv = 8'($urandom_range(0, 255));
        16:      conv = CHR_U;
        17, 18:  conv = CHR_X;
        default: conv = CHR_D;
      endcase
      send_fmt(fresh(), conv, random_arg());
    end
  endtask

  task automatic run_directed();
    // top byte echoed, all-ones argument on a plain character
    send_fmt(1'b1, 8'hFF, '1);
    // literal percent
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_PCT, 64'd0);
    // character conversion takes the low byte only
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_C, '1);
    // most negative int, upper argument bits ignored
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_D, 64'hFFFF_FFFF_8000_0000);
    // three size letters clamp to long long, most negative 64-bit value
    send_fmt(1'b0, CHR_PCT, 64'd0);
    repeat (3) send_fmt(1'b0, CHR_L, 64'd0);
    send_fmt(1'b0, CHR_I, 64'h8000_0000_0000_0000);
    // zero flag and width digit ignored, precision zero means none
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_ZERO, 64'd0);
    send_fmt(1'b0, CHR_ZERO + 8'd5, 64'd0);
    send_fmt(1'b0, CHR_DOT, 64'd0);
    send_fmt(1'b0, CHR_ZERO, 64'd0);
    send_fmt(1'b0, CHR_U, 64'd0);
    // later precision digit replaces the earlier one
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_DOT, 64'd0);
    send_fmt(1'b0, CHR_ZERO + 8'd3, 64'd0);
    send_fmt(1'b0, CHR_ZERO + 8'd7, 64'd0);
    send_fmt(1'b0, CHR_X, 64'd1);
    // null pointer text, then a full pointer
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_P, 64'd0);
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_P, 64'h0123_4567_89AB_CDEF);
    // string conversion is unsupported and swallowed
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_S, 64'd0);
    // NUL ends the string and closes the escape
    send_fmt(1'b0, CHR_PCT, 64'd0);
    send_fmt(1'b0, CHR_NUL, 64'd0);
  endtask

  task automatic run_random();
    int  start;
    bit  held;
    bit  drained;
    start   = sent_count;
    held    = 1'b0;
    drained = 1'b0;
    while (sent_count - start < RANDOM_ITEMS) begin
      if (!held && sent_count - start >= HOLD_AT) begin
        held     = 1'b1;
        hold_off = 1'b1;
      end
      if (!drained && sent_count - start >= DRAIN_AT) begin
        drained = 1'b1;
        wait_drained();
      end
      if (sent_count - start >= CALM_FROM) quiet = 1'b1;
      send_random_spec();
    end
  endtask

  // main sequence: reset, directed, random, drain, verdict
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    sent_count    = 0;
    quiet         = 1'b0;
    hold_off      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // quiet tail catches any character nobody asked for
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("printf_integer_formatter: match");
    end else begin
      $display("printf_integer_formatter: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pif_pkg.sv
rtl/core/printf_integer_formatter.sv
verif/pif_format_checker.sv
verif/tb.sv
